/* sv/text_marquee_window_macros.svh */
// assertion macros for the text marquee window checker
// no dependencies; included by the checker file
`ifndef TEXT_MARQUEE_WINDOW_MACROS_SVH
`define TEXT_MARQUEE_WINDOW_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TMW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TMW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tmw_pkg.sv */
// shared types and constants for the text marquee window
// no dependencies; imported by the top level and the checker
`timescale 1ns / 1ps

package tmw_pkg;

	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned COL_W      = 4;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned WIN_W      = 5;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned TICK_W     = 16;
	localparam int unsigned POS_W      = 9;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned WINDOW_MAX = 16;
	localparam int unsigned RESULT_CAP = 16;
	localparam int unsigned DELIM_LEN  = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXT_LENGTH   = 2'd0,
		REG_WINDOW_LENGTH = 2'd1,
		REG_SCROLL_PERIOD = 2'd2
	} tmw_reg_t;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_RENDER = 1'b1
	} tmw_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_RENDER
	} tmw_state_t;

	// column in flight between the store read and the output register
	typedef struct packed {
		logic              is_delim;
		logic [CHAR_W-1:0] delim;
		logic [COL_W-1:0]  column;
		logic              last;
	} tmw_col_t;

	// delimiter " ** " that closes the ring
	function automatic logic [CHAR_W-1:0] delim_char(input logic [1:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			2'd0: ch = 8'h20;
			2'd1: ch = 8'h2A;
			2'd2: ch = 8'h2A;
			default: ch = 8'h20;
		endcase
		return ch;
	endfunction

endpackage

/* sv/tmw_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tmw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/text_marquee_window.sv */
// text marquee window: text store in ram, window render with scroll step
// depends on tmw_pkg and tmw_ram
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata {tick_count, char_value, char_index}, tuser req_type
// m_*       out  m_tvalid/m_tready  tdata {4'b0, out_column, out_char}, tlast last_char
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// a load-char request leaves the input ready; a render holds it not ready until it ends,
// waiting on the bit-serial remainder unit (tick_count mod scroll_period, 16 steps) that
// gates the scroll step; columns stream out one per cycle alongside it while not stalled; a
// stalled output holds back column reads, and the render ends once all are issued and the
// remainder is done; reset clears control and registers only; the text store is not cleared

module text_marquee_window
	import tmw_pkg::*;
#(
	parameter int unsigned TEXT_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // char_index[7:0], char_value[15:8], tick_count[31:16]
	input  logic                  s_tuser,   // req_type[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // out_char[7:0], out_column[11:8], zero[15:12]
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned AW      = $clog2(TEXT_DEPTH);
	localparam int unsigned WIN_CAP = (WINDOW_MAX < RESULT_CAP) ? WINDOW_MAX : RESULT_CAP;

	// input fields
	logic [LEN_W-1:0]  char_index;
	logic [CHAR_W-1:0] char_value;
	logic [TICK_W-1:0] tick_count;

	assign char_index = s_tdata[7:0];
	assign char_value = s_tdata[15:8];
	assign tick_count = s_tdata[31:16];

	// configuration registers
	logic [LEN_W-1:0]    text_length_q;
	logic [WIN_W-1:0]    window_length_q;
	logic [PERIOD_W-1:0] scroll_period_q;

	// scroll state; scroll_addr_q tracks scroll_pos_q modulo the store depth
	logic [POS_W-1:0] scroll_pos_q;
	logic [AW-1:0]    scroll_addr_q;
	logic             step_armed_q;

	// render control
	tmw_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  col_q;
	logic [POS_W-1:0]  p_q;
	logic [AW-1:0]     addr_q;

	// remainder unit
	logic [TICK_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0]    div_cnt_q;

	// column pipeline and output register
	logic              s1_valid_s1;
	tmw_col_t          col_s1;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_last_q;

	logic [CHAR_W-1:0] ram_rdata;

	// handshake and decode
	logic in_acc, load_acc, render_acc, in_render, render_done;
	logic issue, s1_move, is_delim, rd_en, wr_en;

	// start-of-render values
	logic [WIN_W-1:0]  win_eff;
	logic              fits;
	logic [CNT_W-1:0]  count_start;
	logic [POS_W-1:0]  ring;

	// walk through the ring
	logic [POS_W-1:0]  p_inc;
	logic              p_wrap;
	logic [AW-1:0]     addr_inc;
	tmw_col_t          col_d;

	// remainder step
	logic [PERIOD_W-1:0] divisor;
	logic [PERIOD_W:0]   trial;
	logic                trial_ge;

	// scroll step
	logic [POS_W-1:0] pos_inc;
	logic             pos_wrap;

	assign in_acc     = s_tvalid & s_tready;
	assign load_acc   = in_acc & (s_tuser == REQ_LOAD);
	assign render_acc = in_acc & (s_tuser == REQ_RENDER);

	// window clamp; the text is shown whole when it fits
	assign win_eff     = (window_length_q > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : window_length_q;
	assign fits        = text_length_q <= LEN_W'(win_eff);
	assign count_start = fits ? text_length_q[CNT_W-1:0] : win_eff;
	assign ring        = {1'b0, text_length_q} + POS_W'(DELIM_LEN);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (render_acc) begin
					state_d = ST_RENDER;
				end
			end
			ST_RENDER: begin
				if (render_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		in_render = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_RENDER: in_render = 1'b1;
			default: begin
				s_tready  = 1'b0;
				in_render = 1'b0;
			end
		endcase
	end

	// a column is issued when the read stage is free or drains this cycle
	assign s1_move     = s1_valid_s1 & (~out_valid_q | m_tready);
	assign issue       = in_render & (col_q != cnt_q) & (~s1_valid_s1 | s1_move);
	assign render_done = in_render & (col_q == cnt_q) & (div_cnt_q == '0);

	// delimiter positions sit past the text
	assign is_delim = p_q >= {1'b0, text_length_q};
	assign rd_en    = issue & ~is_delim;
	assign p_inc    = p_q + POS_W'(1);
	assign p_wrap   = p_inc == ring;
	assign addr_inc = (addr_q == AW'(TEXT_DEPTH - 1)) ? '0 : addr_q + AW'(1);

	always_comb begin
		col_d.is_delim = is_delim;
		col_d.delim    = delim_char(p_q[1:0] - text_length_q[1:0]);
		col_d.column   = col_q[COL_W-1:0];
		col_d.last     = (col_q + CNT_W'(1)) == cnt_q;
	end

	// writes beyond the store are dropped
	assign wr_en = load_acc & ({1'b0, char_index} < (LEN_W + 1)'(TEXT_DEPTH));

	tmw_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (TEXT_DEPTH)
	) u_text_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (char_index[AW-1:0]),
		.wr_data (char_value),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (ram_rdata)
	);

	// restoring remainder, one dividend bit per cycle; period zero acts as one
	assign divisor  = (scroll_period_q == '0) ? PERIOD_W'(1) : scroll_period_q;
	assign trial    = {rem_q, dvd_q[TICK_W-1]};
	assign trial_ge = trial >= {1'b0, divisor};

	// scroll step, wraps at text length plus delimiter
	assign pos_inc  = scroll_pos_q + POS_W'(1);
	assign pos_wrap = pos_inc == ring;

	// configuration and scroll position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q   <= '0;
			window_length_q <= WIN_W'(16);
			scroll_period_q <= PERIOD_W'(8);
			scroll_pos_q    <= '0;
			scroll_addr_q   <= '0;
			step_armed_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (tmw_reg_t'(cfg_index))
					REG_TEXT_LENGTH: begin
						text_length_q <= cfg_wdata[LEN_W-1:0];
						scroll_pos_q  <= '0;
						scroll_addr_q <= '0;
					end
					REG_WINDOW_LENGTH: window_length_q <= cfg_wdata[WIN_W-1:0];
					REG_SCROLL_PERIOD: scroll_period_q <= cfg_wdata[PERIOD_W-1:0];
					default: ;
				endcase
			end else if (render_done) begin
				if (rem_q == '0) begin
					if (!step_armed_q) begin
						scroll_pos_q  <= pos_wrap ? '0 : pos_inc;
						scroll_addr_q <= pos_wrap ? '0 :
							((scroll_addr_q == AW'(TEXT_DEPTH - 1)) ? '0
								: scroll_addr_q + AW'(1));
						step_armed_q  <= 1'b1;
					end
				end else begin
					step_armed_q <= 1'b0;
				end
			end
		end
	end

	// render control and remainder unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			col_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (render_acc) begin
				cnt_q     <= count_start;
				col_q     <= '0;
				div_cnt_q <= CNT_W'(TICK_W);
			end else begin
				if (issue) begin
					col_q <= col_q + CNT_W'(1);
				end
				if (div_cnt_q != '0) begin
					div_cnt_q <= div_cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// ring walk and remainder datapath
	always_ff @(posedge clk) begin
		if (render_acc) begin
			p_q    <= fits ? '0 : scroll_pos_q;
			addr_q <= fits ? '0 : scroll_addr_q;
			dvd_q  <= tick_count;
			rem_q  <= '0;
		end else begin
			if (issue) begin
				p_q    <= p_wrap ? '0 : p_inc;
				addr_q <= p_wrap ? '0 : addr_inc;
			end
			if (div_cnt_q != '0) begin
				rem_q <= trial_ge ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
				dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			end
		end
	end

	// read stage valid and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the read stage and the output register
	always_ff @(posedge clk) begin
		if (issue) begin
			col_s1 <= col_d;
		end
		if (s1_move) begin
			out_char_q <= col_s1.is_delim ? col_s1.delim : ram_rdata;
			out_col_q  <= col_s1.column;
			out_last_q <= col_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_col_q, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

/* sv/tmw_checker.sv */
// port-level checker for the text marquee window, bound to the top level
// depends on tmw_pkg and text_marquee_window_macros.svh
`timescale 1ns / 1ps
`include "text_marquee_window_macros.svh"

module tmw_checker
	import tmw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [31:0]           s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [15:0]           m_tdata,
	input logic                  m_tlast,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// expected column of the next result
	logic [COL_W-1:0] exp_col_q;
	logic             cfg_seen;

	assign cfg_seen = cfg_we & (cfg_index != '0 | cfg_wdata != '0 | s_tdata != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_col_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_col_q <= m_tlast ? '0 : exp_col_q + COL_W'(1);
		end
	end

	`TMW_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`TMW_ASSERT_NOW(a_col_seq, clk, arst_n, m_tvalid, m_tdata[11:8] == exp_col_q, "column out of sequence")
	`TMW_ASSERT_NEXT(a_load_fast, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_LOAD) && !cfg_seen, s_tready, "load request stalled input")
	`TMW_ASSERT_NEXT(a_render_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_RENDER), !s_tready, "render accepted back to back")

endmodule

bind text_marquee_window tmw_checker u_tmw_checker (.*);
